[src/dpbm_pkg.sv]
// ----------------------------------------------------------------------------
// dpbm_pkg
// Shared types and constants of the decoded picture buffer manager.
// ----------------------------------------------------------------------------
package dpbm_pkg;

    localparam int CELLS   = 16;   // reference list entries that are emitted
    localparam int SLOT_W  = 5;
    localparam int POS_W   = 4;
    localparam int ORDER_W = 32;
    localparam int FRAME_W = 16;
    localparam int KEY_W   = 33;   // order-count distance needs one bit more
    localparam int CNUM_W  = 5;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SLOT   = 2'd1;
    localparam logic [1:0] ST_NO_FLIGHT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLAIM,
        S_FEED,
        S_SETTLE,
        S_EMIT,
        S_ERR
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } t_entry;

    typedef struct packed {
        logic clr;     // empty every cell
        logic ins;     // insertion sort: hold or pass the travelling entry
        logic shift;   // move the held entries one cell towards the head
        logic b_mode;  // ascending distance; else descending frame number
    } t_cell_ctl;

endpackage

[src/dpbm_cell.sv]
// ----------------------------------------------------------------------------
// dpbm_cell
// One cell of the systolic insertion sorter: keeps one list entry and passes
// the entry that ranks later on to its right-hand neighbour.
// ----------------------------------------------------------------------------
module dpbm_cell
    import dpbm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_in,
    input  t_entry    i_right,
    output t_entry    o_hold,
    output t_entry    o_pass
);

    t_entry r_hold;
    t_entry r_pass;
    logic   w_before;

    // Equal keys rank by slot: slots are fed in ascending order, so a displaced
    // entry can overtake a later one further down and still land ahead of it
    always_comb begin
        if (!r_hold.valid) begin
            w_before = 1'b1;
        end else if (i_in.key == r_hold.key) begin
            w_before = (i_in.slot < r_hold.slot);
        end else if (i_ctl.b_mode) begin
            w_before = (i_in.key < r_hold.key);
        end else begin
            w_before = (i_in.key > r_hold.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold.valid <= 1'b0;
            r_pass.valid <= 1'b0;
        end else if (i_ctl.clr) begin
            r_hold.valid <= 1'b0;
            r_pass.valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_hold       <= i_right;
            r_pass.valid <= 1'b0;
        end else if (i_ctl.ins) begin
            if (i_in.valid && w_before) begin
                r_hold <= i_in;
                r_pass <= r_hold;
            end else begin
                r_pass <= i_in;
            end
        end
    end

    assign o_hold = r_hold;
    assign o_pass = r_pass;

endmodule

[src/decoded_picture_buffer_manager.sv]
// ----------------------------------------------------------------------------
// decoded_picture_buffer_manager
// Slot table of decoded pictures and default reference list ordering.
// ----------------------------------------------------------------------------
// One slice descriptor is taken while busy is low. A first slice scans the
// N = min(num_slots, SLOTS) slots once to find a free slot or the oldest
// non-reference one; the list build then walks the slots again, one per cycle,
// into a 16-cell systolic sorter, which settles and is then shifted out one
// entry per cycle. An item gives 1 to 16 results.
// Results appear for a single cycle on o_strobe and cannot be held off, so
// the receiver must take every one; busy stays high until the last has gone.
// ----------------------------------------------------------------------------
module decoded_picture_buffer_manager
    import dpbm_pkg::*;
#(
    parameter int SLOTS = 17
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [CNUM_W-1:0]         i_cfg_wr_data,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_is_idr,
    input  logic                      i_first_slice,
    input  logic                      i_is_b_slice,
    input  logic                      i_is_ref_pic,
    input  logic signed [ORDER_W-1:0] i_pic_order,
    input  logic [FRAME_W-1:0]        i_frame_number,
    output logic                      o_strobe,
    output logic [1:0]                o_status,
    output logic [SLOT_W-1:0]         o_dest_slot,
    output logic                      o_has_ref,
    output logic [SLOT_W-1:0]         o_ref_slot,
    output logic [POS_W-1:0]          o_ref_position,
    output logic                      o_last
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int WW = $clog2(CELLS);

    t_state r_state, n_state;

    logic [CNUM_W-1:0]         r_num_slots;
    logic [SLOTS-1:0]          r_in_use;
    logic [SLOTS-1:0]          r_is_ref;
    logic signed [ORDER_W-1:0] r_order [SLOTS];
    logic [FRAME_W-1:0]        r_frame [SLOTS];
    logic [IW-1:0]             r_fl_slot;
    logic                      r_fl_valid;

    logic                      r_b;
    logic                      r_isref;
    logic signed [ORDER_W-1:0] r_cur;
    logic [FRAME_W-1:0]        r_fnum;

    logic [CW-1:0]             r_idx;
    logic                      r_free_found;
    logic [IW-1:0]             r_free_idx;
    logic                      r_best_valid;
    logic [IW-1:0]             r_best_idx;
    logic signed [ORDER_W-1:0] r_best_order;
    logic [WW-1:0]             r_wait;
    logic [POS_W-1:0]          r_pos;
    logic [1:0]                r_err_code;

    logic [CW-1:0]             w_n;
    logic                      w_done;
    logic [IW-1:0]             w_ridx;
    logic [IW-1:0]             w_claim_idx;
    logic                      w_claim_ok;
    logic signed [KEY_W-1:0]   w_diff;
    logic [KEY_W-1:0]          w_dist;
    logic                      w_qual;
    logic                      w_last;
    t_entry                    w_feed;
    t_cell_ctl                 w_ctl;
    t_entry                    w_hold [CELLS];
    t_entry                    w_pass [CELLS];

    // Slot count above SLOTS acts as SLOTS
    assign w_n = ({1'b0, r_num_slots} > (CNUM_W + 1)'(SLOTS)) ? CW'(SLOTS)
                                                              : CW'(r_num_slots);
    assign w_done      = (r_idx >= w_n);
    assign w_ridx      = r_idx[IW-1:0];
    assign w_claim_ok  = r_free_found || r_best_valid;
    assign w_claim_idx = r_free_found ? r_free_idx : r_best_idx;

    assign w_diff = {r_order[w_ridx][ORDER_W-1], r_order[w_ridx]}
                  - {r_cur[ORDER_W-1], r_cur};
    assign w_dist = w_diff[KEY_W-1] ? KEY_W'(-w_diff) : KEY_W'(w_diff);
    assign w_qual = r_in_use[w_ridx] && r_is_ref[w_ridx] && (w_ridx != r_fl_slot);

    assign w_last = !w_hold[1].valid;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_first_slice) begin
                        n_state = S_CLAIM;
                    end else if (!r_fl_valid) begin
                        n_state = S_ERR;
                    end else begin
                        n_state = S_FEED;
                    end
                end
            end
            S_CLAIM: begin
                if (w_done) begin
                    n_state = w_claim_ok ? S_FEED : S_ERR;
                end
            end
            S_FEED: begin
                if (w_done) begin
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                if (r_wait == WW'(CELLS - 1)) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    always_comb begin
        busy           = 1'b1;
        o_strobe       = 1'b0;
        o_status       = ST_OK;
        o_dest_slot    = '0;
        o_has_ref      = 1'b0;
        o_ref_slot     = '0;
        o_ref_position = '0;
        o_last         = 1'b0;
        w_ctl          = '{clr: 1'b0, ins: 1'b0, shift: 1'b0, b_mode: r_b};
        w_feed         = '{valid: 1'b0, slot: SLOT_W'(w_ridx),
                           key: r_b ? w_dist : KEY_W'(r_frame[w_ridx])};
        unique case (r_state)
            S_IDLE: begin
                busy      = 1'b0;
                w_ctl.clr = 1'b1;
            end
            S_CLAIM: begin
            end
            S_FEED: begin
                w_ctl.ins    = 1'b1;
                w_feed.valid = !w_done && w_qual;
            end
            S_SETTLE: begin
                w_ctl.ins = 1'b1;
            end
            S_EMIT: begin
                w_ctl.shift = 1'b1;
                o_strobe    = 1'b1;
                o_dest_slot = SLOT_W'(r_fl_slot);
                o_has_ref   = w_hold[0].valid;
                o_last      = w_last;
                if (w_hold[0].valid) begin
                    o_ref_slot     = w_hold[0].slot;
                    o_ref_position = r_pos;
                end
            end
            S_ERR: begin
                o_strobe = 1'b1;
                o_status = r_err_code;
                o_last   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_slots <= CNUM_W'(2);
            r_in_use    <= '0;
            r_is_ref    <= '0;
            r_fl_slot   <= '0;
            r_fl_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_num_slots <= i_cfg_wr_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_pos <= '0;
                    if (start) begin
                        r_b          <= i_is_b_slice;
                        r_isref      <= i_is_ref_pic;
                        r_cur        <= i_pic_order;
                        r_fnum       <= i_frame_number;
                        r_idx        <= '0;
                        r_free_found <= 1'b0;
                        r_best_valid <= 1'b0;
                        r_err_code   <= ST_NO_FLIGHT;
                        if (i_is_idr) begin
                            r_in_use <= '0;
                            r_is_ref <= '0;
                        end
                    end
                end
                S_CLAIM: begin
                    if (!w_done) begin
                        r_idx <= r_idx + CW'(1);
                        if (!r_in_use[w_ridx] && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= w_ridx;
                        end
                        // strict compare: the lowest slot wins on a tie
                        if (!r_is_ref[w_ridx] &&
                            (!r_best_valid || (r_order[w_ridx] < r_best_order))) begin
                            r_best_valid <= 1'b1;
                            r_best_idx   <= w_ridx;
                            r_best_order <= r_order[w_ridx];
                        end
                    end else if (w_claim_ok) begin
                        r_idx                 <= '0;
                        r_in_use[w_claim_idx] <= 1'b1;
                        r_is_ref[w_claim_idx] <= r_isref;
                        r_order[w_claim_idx]  <= r_cur;
                        r_frame[w_claim_idx]  <= r_fnum;
                        r_fl_slot             <= w_claim_idx;
                        r_fl_valid            <= 1'b1;
                    end else begin
                        r_err_code <= ST_NO_SLOT;
                    end
                end
                S_FEED: begin
                    r_wait <= '0;
                    if (!w_done) begin
                        r_idx <= r_idx + CW'(1);
                    end
                end
                S_SETTLE: begin
                    r_wait <= r_wait + WW'(1);
                end
                S_EMIT: begin
                    r_pos <= r_pos + POS_W'(1);
                end
                S_ERR: begin
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- sorter
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        t_entry w_in;
        t_entry w_right;

        if (g == 0) begin : g_head
            assign w_in = w_feed;
        end else begin : g_body
            assign w_in = w_pass[g-1];
        end

        if (g == CELLS - 1) begin : g_tail
            assign w_right = '0;
            // the entry pushed out here ranks beyond the emitted list
            dpbm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_in    (w_in),
                .i_right (w_right),
                .o_hold  (w_hold[g]),
                .o_pass  (w_pass[g])
            );
        end else begin : g_mid
            assign w_right = w_hold[g+1];
            dpbm_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_in    (w_in),
                .i_right (w_right),
                .o_hold  (w_hold[g]),
                .o_pass  (w_pass[g])
            );
        end
    end

endmodule

[src/dpbm_checker.sv]
// ----------------------------------------------------------------------------
// dpbm_checker
// Port-level checks of the decoded picture buffer manager, bound to the top.
// ----------------------------------------------------------------------------
module dpbm_checker
    import dpbm_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [1:0] o_status,
    input logic       o_has_ref,
    input logic       o_last
);

    // results only while a transaction is being worked on
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result shown while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> (!busy && !o_strobe))
        else $error("block not idle after final result");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_has_ref) |-> o_last)
        else $error("result without list entry is not final");

    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status != ST_OK)) |-> (o_last && !o_has_ref))
        else $error("error result carries a list entry or is not final");

endmodule

bind decoded_picture_buffer_manager dpbm_checker u_dpbm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_status (o_status),
    .o_has_ref(o_has_ref),
    .o_last   (o_last)
);

[tb/sv/decoded_picture_buffer_manager_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decoded_picture_buffer_manager_tb
// Self-checking bench for the picture slot table and default reference list.
// Slice descriptors go in on start/busy. A scoreboard keeps its own slot
// table and predicts every list entry, which is checked field by field
// against the strobed results. Directed slices cover the corner cases and
// random picture sequences follow under several slot counts.
// ----------------------------------------------------------------------------
module decoded_picture_buffer_manager_tb;
    import dpbm_pkg::*;

    localparam int NSLOTS = 17;
    localparam logic signed [ORDER_W-1:0] POC_MIN = 32'sh8000_0000;
    localparam logic signed [ORDER_W-1:0] POC_MAX = 32'sh7fff_ffff;

    typedef struct {
        bit                        idr;
        bit                        first;
        bit                        bslice;
        bit                        refpic;
        logic signed [ORDER_W-1:0] poc;
        logic [FRAME_W-1:0]        fnum;
    } t_slice;

    typedef struct {
        logic [1:0]        status;
        logic [SLOT_W-1:0] dest;
        logic              has;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  pos;
        logic              last;
    } t_list_entry;

    class ref_list_scoreboard;
        bit                        in_use [NSLOTS];
        bit                        is_ref [NSLOTS];
        logic signed [ORDER_W-1:0] order  [NSLOTS];
        logic [FRAME_W-1:0]        frame  [NSLOTS];
        int                        flight;
        bit                        flight_ok;
        logic [CNUM_W-1:0]         slots_cfg;
        t_list_entry               pending_q[$];
        int errors, checked, err_status, longest, slices;

        function new();
            for (int i = 0; i < NSLOTS; i++) begin
                in_use[i] = 1'b0;
                is_ref[i] = 1'b0;
                order[i]  = '0;
                frame[i]  = '0;
            end
            flight     = 0;
            flight_ok  = 1'b0;
            slots_cfg  = 5'd2;
            errors     = 0;
            checked    = 0;
            err_status = 0;
            longest    = 0;
            slices     = 0;
        endfunction

        function void set_slots(logic [CNUM_W-1:0] v);
            slots_cfg = v;
        endfunction

        function void push_entry(logic [1:0] st, int dest, bit has, int slot, int pos,
                                 bit last);
            t_list_entry e;
            e.status = st;
            e.dest   = dest[SLOT_W-1:0];
            e.has    = has;
            e.slot   = slot[SLOT_W-1:0];
            e.pos    = pos[POS_W-1:0];
            e.last   = last;
            pending_q.push_back(e);
        endfunction

        // 33-bit safe absolute order-count distance
        function longint poc_gap(int s, logic signed [ORDER_W-1:0] cur);
            longint d;
            d = longint'(order[s]) - longint'(cur);
            return (d < 0) ? -d : d;
        endfunction

        function void note_slice(t_slice s);
            int n, pick, cnt, key, j;
            int list [NSLOTS];
            bit move;
            n = (slots_cfg > NSLOTS) ? NSLOTS : int'(slots_cfg);
            slices++;
            if (s.idr) begin
                for (int i = 0; i < NSLOTS; i++) begin
                    in_use[i] = 1'b0;
                    is_ref[i] = 1'b0;
                end
            end
            if (s.first) begin
                pick = -1;
                for (int i = 0; i < n; i++)
                    if (pick < 0 && !in_use[i]) pick = i;
                // table full: evict oldest non-reference, lowest slot on a tie
                if (pick < 0)
                    for (int i = 0; i < n; i++)
                        if (!is_ref[i] && (pick < 0 || order[i] < order[pick])) pick = i;
                if (pick < 0) begin
                    push_entry(ST_NO_SLOT, 0, 1'b0, 0, 0, 1'b1);
                    err_status++;
                    return;
                end
                in_use[pick] = 1'b1;
                is_ref[pick] = s.refpic;
                order[pick]  = s.poc;
                frame[pick]  = s.fnum;
                flight       = pick;
                flight_ok    = 1'b1;
            end else if (!flight_ok) begin
                push_entry(ST_NO_FLIGHT, 0, 1'b0, 0, 0, 1'b1);
                err_status++;
                return;
            end

            cnt = 0;
            for (int i = 0; i < n; i++)
                if (in_use[i] && is_ref[i] && i != flight) begin
                    list[cnt] = i;
                    cnt++;
                end

            // stable insertion sort
            for (int i = 1; i < cnt; i++) begin
                key = list[i];
                j   = i;
                while (j > 0) begin
                    if (s.bslice) move = poc_gap(list[j-1], s.poc) > poc_gap(key, s.poc);
                    else          move = frame[list[j-1]] < frame[key];
                    if (!move) break;
                    list[j] = list[j-1];
                    j--;
                end
                list[j] = key;
            end

            if (cnt == 0) begin
                push_entry(ST_OK, flight, 1'b0, 0, 0, 1'b1);
                return;
            end
            if (cnt > CELLS) cnt = CELLS;
            if (cnt > longest) longest = cnt;
            for (int k = 0; k < cnt; k++)
                push_entry(ST_OK, flight, 1'b1, list[k], k, (k + 1 == cnt));
        endfunction

        function void cmp_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_list_entry got);
            t_list_entry want;
            checked++;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result, expected none actual status=%0d slot=%0d",
                         $time, got.status, got.slot);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            cmp_field("status",       32'(want.status), 32'(got.status));
            cmp_field("dest_slot",    32'(want.dest),   32'(got.dest));
            cmp_field("has_ref",      32'(want.has),    32'(got.has));
            cmp_field("ref_slot",     32'(want.slot),   32'(got.slot));
            cmp_field("ref_position", 32'(want.pos),    32'(got.pos));
            cmp_field("last",         32'(want.last),   32'(got.last));
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_wr_en;
    logic [CNUM_W-1:0]         i_cfg_wr_data;
    logic                      start;
    logic                      busy;
    logic                      i_is_idr;
    logic                      i_first_slice;
    logic                      i_is_b_slice;
    logic                      i_is_ref_pic;
    logic signed [ORDER_W-1:0] i_pic_order;
    logic [FRAME_W-1:0]        i_frame_number;
    logic                      o_strobe;
    logic [1:0]                o_status;
    logic [SLOT_W-1:0]         o_dest_slot;
    logic                      o_has_ref;
    logic [SLOT_W-1:0]         o_ref_slot;
    logic [POS_W-1:0]          o_ref_position;
    logic                      o_last;

    ref_list_scoreboard sb = new();
    t_list_entry        seen;
    bit                 quiet;
    int                 poc_base;
    logic [FRAME_W-1:0] frame_ctr;
    int                 settings_used;

    decoded_picture_buffer_manager #(
        .SLOTS(NSLOTS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .start          (start),
        .busy           (busy),
        .i_is_idr       (i_is_idr),
        .i_first_slice  (i_first_slice),
        .i_is_b_slice   (i_is_b_slice),
        .i_is_ref_pic   (i_is_ref_pic),
        .i_pic_order    (i_pic_order),
        .i_frame_number (i_frame_number),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_dest_slot    (o_dest_slot),
        .o_has_ref      (o_has_ref),
        .o_ref_slot     (o_ref_slot),
        .o_ref_position (o_ref_position),
        .o_last         (o_last)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // results cannot be held off: take one on every strobed edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            seen.status = o_status;
            seen.dest   = o_dest_slot;
            seen.has    = o_has_ref;
            seen.slot   = o_ref_slot;
            seen.pos    = o_ref_position;
            seen.last   = o_last;
            sb.check_result(seen);
        end
    end

    function automatic t_slice mk(bit idr, bit first, bit bslice, bit refpic,
                                  logic signed [ORDER_W-1:0] poc, logic [FRAME_W-1:0] fnum);
        t_slice s;
        s.idr    = idr;
        s.first  = first;
        s.bslice = bslice;
        s.refpic = refpic;
        s.poc    = poc;
        s.fnum   = fnum;
        return s;
    endfunction

    function automatic logic signed [ORDER_W-1:0] rand_poc();
        if ($urandom_range(7) == 0) return $urandom;
        return poc_base + $urandom_range(12) - 6;
    endfunction

    task automatic send_slice(t_slice s);
        i_is_idr       <= s.idr;
        i_first_slice  <= s.first;
        i_is_b_slice   <= s.bslice;
        i_is_ref_pic   <= s.refpic;
        i_pic_order    <= s.poc;
        i_frame_number <= s.fnum;
        forever begin
            start <= (!quiet && $urandom_range(99) < 13) ? 1'b0 : 1'b1;
            @(posedge i_clk);
            if (start && !busy) break;
        end
        sb.note_slice(s);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_q.size() != 0 || busy);
    endtask

    task automatic write_slots(logic [CNUM_W-1:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_slots(v);
        settings_used++;
    endtask

    // one picture: a first slice then up to two further slices of it
    task automatic send_picture(output int sent);
        t_slice pic;
        int     extra;
        poc_base += 2;
        frame_ctr = ($urandom_range(3) == 0) ? FRAME_W'($urandom) : frame_ctr + 1'b1;
        pic = mk($urandom_range(9) == 0, 1'b1, 1'($urandom_range(1)),
                 $urandom_range(2) != 0, rand_poc(), frame_ctr);
        send_slice(pic);
        extra = $urandom_range(2);
        for (int k = 0; k < extra; k++)
            send_slice(mk(1'b0, 1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)),
                          ($urandom_range(4) == 0) ? rand_poc() : pic.poc, pic.fnum));
        sent = 1 + extra;
    endtask

    task automatic run_phase(int items);
        int sent, got_n;
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(99) < 15) begin
                send_slice(mk($urandom_range(15) == 0, 1'($urandom_range(1)),
                              1'($urandom_range(1)), 1'($urandom_range(1)),
                              $urandom, FRAME_W'($urandom)));
                sent++;
            end else begin
                send_picture(got_n);
                sent += got_n;
            end
        end
        drain();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_wr_en    <= 1'b0;
        i_cfg_wr_data  <= '0;
        start          <= 1'b0;
        i_is_idr       <= 1'b0;
        i_first_slice  <= 1'b0;
        i_is_b_slice   <= 1'b0;
        i_is_ref_pic   <= 1'b0;
        i_pic_order    <= '0;
        i_frame_number <= '0;
        quiet          = 1'b0;
        poc_base       = 0;
        frame_ctr      = '0;
        settings_used  = 1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two slots after reset; nothing in flight yet
        send_slice(mk(1'b0, 1'b0, 1'b0, 1'b1, 0, 0));
        send_slice(mk(1'b1, 1'b0, 1'b1, 1'b0, 5, 9));
        send_slice(mk(1'b1, 1'b1, 1'b0, 1'b1, POC_MIN, 16'h0000));
        send_slice(mk(1'b0, 1'b1, 1'b1, 1'b1, POC_MAX, 16'hffff));
        send_slice(mk(1'b0, 1'b1, 1'b0, 1'b1, 0, 3));        // both slots are references
        send_slice(mk(1'b0, 1'b0, 1'b0, 1'b0, 1, 3));        // failed claim keeps flight
        send_slice(mk(1'b1, 1'b1, 1'b0, 1'b0, 7, 10));
        send_slice(mk(1'b0, 1'b1, 1'b1, 1'b0, 7, 11));
        send_slice(mk(1'b0, 1'b1, 1'b0, 1'b1, 3, 12));       // equal order counts
        send_slice(mk(1'b0, 1'b1, 1'b1, 1'b1, 9, 13));
        drain();

        write_slots(5'd0);
        send_slice(mk(1'b0, 1'b1, 1'b0, 1'b1, 4, 14));
        send_slice(mk(1'b0, 1'b0, 1'b1, 1'b0, 4, 14));       // flight slot beyond the scan
        drain();

        // fill all seventeen slots with references for the longest list
        write_slots(5'd17);
        send_slice(mk(1'b1, 1'b1, 1'b0, 1'b1, 0, 100));
        for (int i = 1; i < NSLOTS; i++)
            send_slice(mk(1'b0, 1'b1, 1'(i % 2), 1'b1,
                          (i == 8) ? POC_MAX : (i == 13) ? POC_MIN : (i * 7) % 9 - 4,
                          (i == 5) ? 16'hffff : FRAME_W'((i * 37) % 8)));
        send_slice(mk(1'b0, 1'b0, 1'b1, 1'b0, 0, 0));
        send_slice(mk(1'b0, 1'b0, 1'b0, 1'b0, -1, 0));
        drain();

        write_slots(5'd2);
        send_slice(mk(1'b0, 1'b0, 1'b1, 1'b1, 2, 0));
        drain();

        write_slots(5'd31);
        run_phase(22);
        write_slots(5'd5);
        quiet = 1'b1;
        run_phase(22);
        quiet = 1'b0;
        write_slots(5'd1);
        run_phase(20);
        write_slots(CNUM_W'($urandom_range(31)));
        run_phase(22);
        write_slots(5'd17);
        run_phase(30);
        write_slots(5'd3);
        run_phase(20);

        repeat (80) @(posedge i_clk);
        $display("Run covered %0d slice descriptors under %0d slot counts, %0d results checked",
                 sb.slices, settings_used, sb.checked);
        $display("Claim or flight errors predicted: %0d, longest reference list: %0d",
                 sb.err_status, sb.longest);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timeout: %0d results still awaited", sb.pending_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/dpbm_pkg.sv
src/dpbm_cell.sv
src/decoded_picture_buffer_manager.sv
src/dpbm_checker.sv
tb/sv/decoded_picture_buffer_manager_tb.sv
